// ----- rtl/vplc_pkg.sv -----
// Shared types and constants of the velocity PI low-pass controller.
`timescale 1ns / 1ps

package vplc_pkg;

  // Field widths
  localparam int unsigned SPEED_W    = 16;
  localparam int unsigned GAIN_W     = 17;
  localparam int unsigned ERR_W      = 18;
  localparam int unsigned INTEG_W    = 15;
  localparam int unsigned DRIVE_W    = 18;
  localparam int unsigned IN_DATA_W  = 3 * SPEED_W;
  localparam int unsigned OUT_DATA_W = 24;

  // Serial multiplier geometry: signed multiplicand, unsigned multiplier
  localparam int unsigned MCAND_W  = ERR_W;
  localparam int unsigned MPLIER_W = GAIN_W;
  localparam int unsigned ACC_W    = 36;
  localparam int unsigned CNT_W    = $clog2(MPLIER_W);
  localparam int unsigned Q_SHIFT  = 16;
  localparam int unsigned QUOT_W   = ACC_W - Q_SHIFT;

  // Low-pass weights in Q16 (0.3 new, 0.7 old)
  localparam logic [MPLIER_W-1:0] NEW_WEIGHT = MPLIER_W'(19661);
  localparam logic [MPLIER_W-1:0] OLD_WEIGHT = MPLIER_W'(45875);

  // Integral clamp, sum width covers integral plus filtered error
  localparam int unsigned SUM_W = ERR_W + 1;
  localparam logic signed [SUM_W-1:0] INTEGRAL_LIMIT = SUM_W'(10000);

  // Drive saturation bounds
  localparam logic signed [QUOT_W-1:0] DRIVE_MAX = QUOT_W'(131071);
  localparam logic signed [QUOT_W-1:0] DRIVE_MIN = -QUOT_W'(131072);

  // Configuration register indexes
  localparam int unsigned CFG_ADDR_W = 1;
  localparam logic [CFG_ADDR_W-1:0] CFG_KP_GAIN = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_KI_GAIN = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILT,
    ST_INTEG,
    ST_DRIVE,
    ST_OUT
  } state_e;

  // Request into the serial multiply-accumulate unit: acc = a*x + b*y
  typedef struct packed {
    logic                       start;
    logic signed [MCAND_W-1:0]  mcand_a;
    logic        [MPLIER_W-1:0] mplier_a;
    logic signed [MCAND_W-1:0]  mcand_b;
    logic        [MPLIER_W-1:0] mplier_b;
  } mac_req_t;

endpackage

// ----- rtl/vplc_smac.sv -----
// Bit-serial dual multiply-accumulate unit, one multiplier bit per cycle.
`timescale 1ns / 1ps

module vplc_smac (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  vplc_pkg::mac_req_t                     req_i,
  output logic                                   done_o,
  output logic signed [vplc_pkg::ACC_W-1:0]      acc_o
);
  import vplc_pkg::*;

  logic                      busy_q, busy_d;
  logic                      done_q, done_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic signed [ACC_W-1:0]   ma_q, ma_d, mb_q, mb_d;
  logic [MPLIER_W-1:0]       xa_q, xa_d, xb_q, xb_d;
  logic signed [ACC_W-1:0]   acc_q, acc_d;
  logic signed [ACC_W-1:0]   part_a, part_b;

  // Partial products of the current multiplier bit
  assign part_a = xa_q[0] ? ma_q : '0;
  assign part_b = xb_q[0] ? mb_q : '0;

  // Load on start, then shift-and-add until all multiplier bits are used
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    ma_d   = ma_q;
    mb_d   = mb_q;
    xa_d   = xa_q;
    xb_d   = xb_q;
    acc_d  = acc_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      ma_d   = ACC_W'(req_i.mcand_a);
      mb_d   = ACC_W'(req_i.mcand_b);
      xa_d   = req_i.mplier_a;
      xb_d   = req_i.mplier_b;
      acc_d  = '0;
    end else if (busy_q) begin
      acc_d = acc_q + part_a + part_b;
      ma_d  = ma_q <<< 1;
      mb_d  = mb_q <<< 1;
      xa_d  = xa_q >> 1;
      xb_d  = xb_q >> 1;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(MPLIER_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath shift registers
  always_ff @(posedge clk_i) begin
    ma_q  <= ma_d;
    mb_q  <= mb_d;
    xa_q  <= xa_d;
    xb_q  <= xb_d;
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign acc_o  = acc_q;

endmodule

// ----- rtl/velocity_pi_lowpass_controller.sv -----
// Top level: velocity PI controller with low-pass filtered error and clamped integral.
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+-----------------------------------------
//  s_axis   | in        | tvalid / tready       | tdata: speed_setpoint, left_count, right_count
//  m_axis   | out       | tvalid / tready       | tdata: drive; tuser: integral_limited
//  cfg      | in        | cfg_valid_i/cfg_ready_o | cfg_addr_i register index, cfg_data_i value
//
// Each item makes two passes through the bit-serial multiply-accumulate unit
// (filter, then drive), with the integral and output sequencing states between and after.
// Reset clears the gains, the filtered error and the integral.
// An item waiting in the output register does not block the next input item;
// a finished drive is held in the sequencer until the output register is free.
// Configuration writes are always taken.
`timescale 1ns / 1ps

module velocity_pi_lowpass_controller (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Input items
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [15:0] speed_setpoint, [31:16] left_count, [47:32] right_count
  input  logic [vplc_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // Result items
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [17:0] drive, [23:18] zero
  output logic [vplc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // [0] integral_limited
  output logic                                m_axis_tuser,
  // Configuration writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [vplc_pkg::CFG_ADDR_W-1:0]     cfg_addr_i,
  input  logic [vplc_pkg::GAIN_W-1:0]         cfg_data_i
);
  import vplc_pkg::*;

  state_e                    state_q, state_d;
  logic [GAIN_W-1:0]         kp_q, ki_q;
  logic signed [ERR_W-1:0]   filt_q;
  logic signed [INTEG_W-1:0] integ_q;
  logic                      limited_q;
  logic                      out_valid_q;
  logic [DRIVE_W-1:0]        out_drive_q;
  logic                      out_flag_q;

  logic                      in_accept;
  logic                      out_free;
  logic                      load_filt, load_integ, load_out;
  mac_req_t                  mac_req;
  logic                      mac_done;
  logic signed [ACC_W-1:0]   mac_acc;

  logic signed [SPEED_W-1:0] target, left, right;
  logic signed [ERR_W-1:0]   err;
  logic signed [ACC_W-1:0]   acc_adj;
  logic signed [QUOT_W-1:0]  quot;
  logic signed [SUM_W-1:0]   sum;
  logic signed [INTEG_W-1:0] integ_new;
  logic                      limited_new;
  logic [DRIVE_W-1:0]        drive_sat;

  assign cfg_ready_o = 1'b1;

  // Input fields and raw speed error
  assign target = s_axis_tdata[SPEED_W-1:0];
  assign left   = s_axis_tdata[2*SPEED_W-1:SPEED_W];
  assign right  = s_axis_tdata[3*SPEED_W-1:2*SPEED_W];
  assign err    = ERR_W'(left) + ERR_W'(right) - ERR_W'(target);

  // Divide the accumulator by 2^16, truncating toward zero
  assign acc_adj = mac_acc + (mac_acc[ACC_W-1] ? ACC_W'((1 << Q_SHIFT) - 1) : ACC_W'(0));
  assign quot    = QUOT_W'(acc_adj >>> Q_SHIFT);

  // Integral update with clamp; landing on the limit is not flagged
  always_comb begin
    sum         = SUM_W'(integ_q) + SUM_W'(filt_q);
    integ_new   = INTEG_W'(sum);
    limited_new = 1'b0;
    if (sum > INTEGRAL_LIMIT) begin
      integ_new   = INTEG_W'(INTEGRAL_LIMIT);
      limited_new = 1'b1;
    end else if (sum < -INTEGRAL_LIMIT) begin
      integ_new   = INTEG_W'(-INTEGRAL_LIMIT);
      limited_new = 1'b1;
    end
  end

  // Drive saturation to 18 bits
  always_comb begin
    if (quot > DRIVE_MAX) begin
      drive_sat = DRIVE_W'(DRIVE_MAX);
    end else if (quot < DRIVE_MIN) begin
      drive_sat = DRIVE_W'(DRIVE_MIN);
    end else begin
      drive_sat = DRIVE_W'(quot);
    end
  end

  assign out_free  = !out_valid_q || m_axis_tready;
  assign in_accept = s_axis_tvalid && s_axis_tready;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_accept) state_d = ST_FILT;
      ST_FILT:  if (mac_done) state_d = ST_INTEG;
      ST_INTEG: state_d = ST_DRIVE;
      ST_DRIVE: if (mac_done) state_d = ST_OUT;
      ST_OUT:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    s_axis_tready    = 1'b0;
    load_filt        = 1'b0;
    load_integ       = 1'b0;
    load_out         = 1'b0;
    mac_req.start    = 1'b0;
    mac_req.mcand_a  = err;
    mac_req.mplier_a = NEW_WEIGHT;
    mac_req.mcand_b  = filt_q;
    mac_req.mplier_b = OLD_WEIGHT;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        mac_req.start = s_axis_tvalid;
      end
      ST_FILT: begin
        load_filt = mac_done;
      end
      ST_INTEG: begin
        load_integ       = 1'b1;
        mac_req.start    = 1'b1;
        mac_req.mcand_a  = filt_q;
        mac_req.mplier_a = kp_q;
        mac_req.mcand_b  = MCAND_W'(integ_new);
        mac_req.mplier_b = ki_q;
      end
      ST_DRIVE: begin
      end
      ST_OUT: begin
        load_out = out_free;
      end
      default: begin
      end
    endcase
  end

  // Control state, gains and loop state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      kp_q        <= '0;
      ki_q        <= '0;
      filt_q      <= '0;
      integ_q     <= '0;
      limited_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        unique case (cfg_addr_i)
          CFG_KP_GAIN: kp_q <= cfg_data_i;
          CFG_KI_GAIN: ki_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (load_filt) filt_q <= ERR_W'(quot);
      if (load_integ) begin
        integ_q   <= integ_new;
        limited_q <= limited_new;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output item register
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_drive_q <= drive_sat;
      out_flag_q  <= limited_q;
    end
  end

  vplc_smac u_smac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mac_req),
    .done_o (mac_done),
    .acc_o  (mac_acc)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_DATA_W'(out_drive_q);
  assign m_axis_tuser  = out_flag_q;

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for the velocity PI low-pass controller: directed plan plus random phases.
`timescale 1ns / 1ps

module tb_top;
  import vplc_pkg::*;

  // Item kinds of the directed plan
  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_e;

  typedef struct packed {
    row_kind_e               kind;
    logic [CFG_ADDR_W-1:0]   addr;
    logic [GAIN_W-1:0]       gain;
    logic [SPEED_W-1:0]      tgt;
    logic [SPEED_W-1:0]      lft;
    logic [SPEED_W-1:0]      rgt;
    logic                    typed;
    logic [DRIVE_W-1:0]      drive;
    logic                    limited;
  } row_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic                      limited;
  } drive_result_t;

  localparam logic [SPEED_W-1:0] S_MIN = 16'h8000;
  localparam logic [SPEED_W-1:0] S_MAX = 16'h7FFF;
  localparam logic [GAIN_W-1:0]  GAIN_UNITY = 17'd65536;
  localparam logic [GAIN_W-1:0]  GAIN_TOP   = 17'h1FFFF;
  localparam longint Q16_ONE   = 65536;
  localparam longint DRV_TOP   = (longint'(1) <<< (DRIVE_W - 1)) - 1;
  localparam longint DRV_BOT   = -(longint'(1) <<< (DRIVE_W - 1));
  localparam int     STALL_LIMIT = 4000;
  localparam int     PHASES      = 10;
  localparam int     PHASE_ITEMS = 150;

  // Directed plan: typed expectations only where gains are zero and the clamp is obvious
  localparam row_t PLAN [26] = '{
    // error 33333 from reset lands exactly on the positive limit: no flag
    '{ROW_ITEM, CFG_KP_GAIN, 17'd0, 16'd0, 16'd16667, 16'd16666, 1'b1, 18'd0, 1'b0},
    '{ROW_ITEM, CFG_KP_GAIN, 17'd0, 16'd0, 16'd16667, 16'd16666, 1'b1, 18'd0, 1'b1},
    '{ROW_ITEM, CFG_KP_GAIN, 17'd0, S_MIN, S_MAX, S_MAX, 1'b1, 18'd0, 1'b1},
    '{ROW_ITEM, CFG_KP_GAIN, 17'd0, S_MAX, S_MIN, S_MIN, 1'b0, 18'd0, 1'b0},
    '{ROW_ITEM, CFG_KP_GAIN, 17'd0, 16'd0, 16'd0, 16'd0, 1'b0, 18'd0, 1'b0},
    '{ROW_ITEM, CFG_KP_GAIN, 17'd0, 16'd0, 16'd0, 16'd0, 1'b0, 18'd0, 1'b0},
    // unity gains
    '{ROW_CFG, CFG_KP_GAIN, GAIN_UNITY, 16'd0, 16'd0, 16'd0, 1'b0, 18'd0, 1'b0},
    '{ROW_CFG, CFG_KI_GAIN, GAIN_UNITY, 16'd0, 16'd0, 16'd0, 1'b0, 18'd0, 1'b0},
    '{ROW_ITEM, CFG_KP_GAIN, 17'd0, 16'd0, 16'd100, 16'hFF9C, 1'b0, 18'd0, 1'b0},
    '{ROW_ITEM, CFG_KP_GAIN, 17'd0, S_MIN, S_MAX, S_MAX, 1'b0, 18'd0, 1'b0},
    '{ROW_ITEM, CFG_KP_GAIN, 17'd0, S_MAX, S_MIN, S_MIN, 1'b0, 18'd0, 1'b0},
    '{ROW_ITEM, CFG_KP_GAIN, 17'd0, S_MIN, S_MIN, S_MIN, 1'b0, 18'd0, 1'b0},
    '{ROW_ITEM, CFG_KP_GAIN, 17'd0, S_MAX, S_MAX, S_MAX, 1'b0, 18'd0, 1'b0},
    // largest gains drive the output into saturation
    '{ROW_CFG, CFG_KP_GAIN, GAIN_TOP, 16'd0, 16'd0, 16'd0, 1'b0, 18'd0, 1'b0},
    '{ROW_CFG, CFG_KI_GAIN, GAIN_TOP, 16'd0, 16'd0, 16'd0, 1'b0, 18'd0, 1'b0},
    '{ROW_ITEM, CFG_KP_GAIN, 17'd0, S_MIN, S_MAX, S_MAX, 1'b0, 18'd0, 1'b0},
    '{ROW_ITEM, CFG_KP_GAIN, 17'd0, S_MIN, S_MAX, S_MAX, 1'b0, 18'd0, 1'b0},
    '{ROW_ITEM, CFG_KP_GAIN, 17'd0, S_MAX, S_MIN, S_MIN, 1'b0, 18'd0, 1'b0},
    '{ROW_ITEM, CFG_KP_GAIN, 17'd0, S_MAX, S_MIN, S_MIN, 1'b0, 18'd0, 1'b0},
    // integral term only
    '{ROW_CFG, CFG_KP_GAIN, 17'd0, 16'd0, 16'd0, 16'd0, 1'b0, 18'd0, 1'b0},
    '{ROW_ITEM, CFG_KP_GAIN, 17'd0, 16'd0, 16'hFFFF, 16'd0, 1'b0, 18'd0, 1'b0},
    '{ROW_ITEM, CFG_KP_GAIN, 17'd0, 16'd0, 16'd1, 16'd0, 1'b0, 18'd0, 1'b0},
    // proportional term only
    '{ROW_CFG, CFG_KP_GAIN, GAIN_TOP, 16'd0, 16'd0, 16'd0, 1'b0, 18'd0, 1'b0},
    '{ROW_CFG, CFG_KI_GAIN, 17'd0, 16'd0, 16'd0, 16'd0, 1'b0, 18'd0, 1'b0},
    '{ROW_ITEM, CFG_KP_GAIN, 17'd0, 16'd0, S_MIN, 16'hFFFF, 1'b0, 18'd0, 1'b0},
    '{ROW_ITEM, CFG_KP_GAIN, 17'd0, 16'd1, 16'd0, 16'd0, 1'b0, 18'd0, 1'b0}
  };

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [IN_DATA_W-1:0]    s_axis_tdata = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0]   m_axis_tdata;
  logic                    m_axis_tuser;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [CFG_ADDR_W-1:0]   cfg_addr_i = '0;
  logic [GAIN_W-1:0]       cfg_data_i = '0;

  // Predictor copy of the controller state and gains
  logic signed [ERR_W-1:0]   filt_state = '0;
  logic signed [INTEG_W-1:0] integ_state = '0;
  logic [GAIN_W-1:0]         kp_reg = '0;
  logic [GAIN_W-1:0]         ki_reg = '0;

  drive_result_t pending_drive_q[$];
  drive_result_t want;
  int            fail_cnt = 0;
  int            quiet_cycles = 0;
  bit            idling_on = 1'b1;

  velocity_pi_lowpass_controller dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // One controller step: low-pass the error, clamp the integral, form the drive
  function automatic drive_result_t advance_speed_loop(input logic [SPEED_W-1:0] tgt,
                                                       input logic [SPEED_W-1:0] lft,
                                                       input logic [SPEED_W-1:0] rgt);
    longint err;
    longint filt;
    longint sum;
    longint acc;
    longint drv;
    drive_result_t res;
    err  = longint'($signed(lft)) + longint'($signed(rgt)) - longint'($signed(tgt));
    filt = (longint'(NEW_WEIGHT) * err + longint'(OLD_WEIGHT) * longint'(filt_state))
           / Q16_ONE;
    sum = longint'(integ_state) + filt;
    res.limited = 1'b0;
    if (sum > longint'(INTEGRAL_LIMIT)) begin
      sum = longint'(INTEGRAL_LIMIT);
      res.limited = 1'b1;
    end else if (sum < -longint'(INTEGRAL_LIMIT)) begin
      sum = -longint'(INTEGRAL_LIMIT);
      res.limited = 1'b1;
    end
    acc = longint'(kp_reg) * filt + longint'(ki_reg) * sum;
    drv = acc / Q16_ONE;
    if (drv > DRV_TOP) drv = DRV_TOP;
    if (drv < DRV_BOT) drv = DRV_BOT;
    filt_state  = filt[ERR_W-1:0];
    integ_state = sum[INTEG_W-1:0];
    res.drive   = drv[DRIVE_W-1:0];
    return res;
  endfunction

  function automatic logic [SPEED_W-1:0] corner_speed();
    case ($urandom_range(0, 4))
      0: return S_MIN;
      1: return S_MAX;
      2: return 16'hFFFF;
      3: return 16'd1;
      default: return 16'd0;
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return GAIN_UNITY;
      2: return GAIN_TOP;
      3: return GAIN_W'($urandom_range(0, 8192));
      default: return GAIN_W'($urandom);
    endcase
  endfunction

  // Present one item and hold it until the block takes it
  task automatic send_item(input logic [SPEED_W-1:0] tgt, input logic [SPEED_W-1:0] lft,
                           input logic [SPEED_W-1:0] rgt);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {rgt, lft, tgt};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic pause_sender();
    if (idling_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(0, 11)) @(negedge clk_i);
    end
  endtask

  // Gains change only once the block has drained
  task automatic write_gain(input logic [CFG_ADDR_W-1:0] addr, input logic [GAIN_W-1:0] value);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_drive_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (addr == CFG_KP_GAIN) kp_reg = value;
    else ki_reg = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Receiver stalls in bursts
  initial begin
    forever begin
      @(negedge clk_i);
      if (idling_on && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(0, 11)) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Compare each result item with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_drive_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, got drive %0d limited %0b",
                 $time, $signed(m_axis_tdata[DRIVE_W-1:0]), m_axis_tuser);
        fail_cnt++;
      end else begin
        want = pending_drive_q.pop_front();
        if (m_axis_tdata !== OUT_DATA_W'({1'b0, want.drive}) ||
            m_axis_tuser !== want.limited) begin
          $display("%0t: result mismatch: expected drive %0d limited %0b (tdata %h), got drive %0d limited %0b (tdata %h)",
                   $time, want.drive, want.limited, OUT_DATA_W'({1'b0, want.drive}),
                   $signed(m_axis_tdata[DRIVE_W-1:0]), m_axis_tuser, m_axis_tdata);
          fail_cnt++;
        end
      end
    end
  end

  // Watchdog on cycles where no channel moves anything
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_top failed");
        $finish;
      end
    end
  end

  initial begin
    drive_result_t res;
    logic [SPEED_W-1:0] tgt;
    logic [SPEED_W-1:0] lft;
    logic [SPEED_W-1:0] rgt;
    int t_i;
    int l_i;
    int e_i;
    int span;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed plan
    foreach (PLAN[k]) begin
      if (PLAN[k].kind == ROW_CFG) begin
        write_gain(PLAN[k].addr, PLAN[k].gain);
      end else begin
        send_item(PLAN[k].tgt, PLAN[k].lft, PLAN[k].rgt);
        res = advance_speed_loop(PLAN[k].tgt, PLAN[k].lft, PLAN[k].rgt);
        if (PLAN[k].typed) begin
          res.drive   = PLAN[k].drive;
          res.limited = PLAN[k].limited;
        end
        pending_drive_q.push_back(res);
        pause_sender();
      end
    end

    // Random phases, each under fresh gains; the last one runs without idling
    for (int phase = 0; phase < PHASES; phase++) begin
      write_gain(CFG_KP_GAIN, pick_gain());
      write_gain(CFG_KI_GAIN, pick_gain());
      idling_on = (phase < PHASES - 1) && ($urandom_range(0, 3) != 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        case ($urandom_range(0, 9))
          0, 1: begin
            tgt = SPEED_W'($urandom);
            lft = SPEED_W'($urandom);
            rgt = SPEED_W'($urandom);
          end
          2: begin
            tgt = corner_speed();
            lft = corner_speed();
            rgt = corner_speed();
          end
          default: begin
            // wheels near target: small error keeps the integral off the clamp
            span = ($urandom_range(0, 3) == 0) ? 3000 : 300;
            e_i = $urandom_range(0, 2 * span);
            e_i -= span;
            t_i = $urandom_range(0, 16000);
            t_i -= 8000;
            l_i = $urandom_range(0, 16000);
            l_i -= 8000;
            tgt = SPEED_W'(t_i);
            lft = SPEED_W'(l_i);
            rgt = SPEED_W'(t_i + e_i - l_i);
          end
        endcase
        send_item(tgt, lft, rgt);
        pending_drive_q.push_back(advance_speed_loop(tgt, lft, rgt));
        pause_sender();
      end
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_drive_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/vplc_pkg.sv
rtl/vplc_smac.sv
rtl/velocity_pi_lowpass_controller.sv
sim/tb_top.sv
